// ----- rtl/core/sexl_pkg.sv -----
// ----------------------------------------------------------------------------
// sexl_pkg: shared types of the S-expression lexer
// Token kinds, lexer modes and the result records passed between the lexer
// core, its response queue and the top level.
// ----------------------------------------------------------------------------
package sexl_pkg;

   // Number of results one character can cause at most
   localparam int unsigned MAX_RESULTS = 3;
   localparam int unsigned COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int unsigned INDEX_W     = $clog2(MAX_RESULTS);

   typedef enum logic [3:0] {
      TOKEN_OPEN   = 4'd0,
      TOKEN_CLOSE  = 4'd1,
      TOKEN_DOT    = 4'd2,
      TOKEN_QUOTE  = 4'd3,
      TOKEN_CONST  = 4'd4,
      TOKEN_SYMCH  = 4'd5,
      TOKEN_SYMEND = 4'd6,
      TOKEN_ERROR  = 4'd7,
      TOKEN_END    = 4'd8
   } token_kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_SIGN = 4'b0010,
      MODE_NUM  = 4'b0100,
      MODE_SYM  = 4'b1000
   } lex_mode_type;

   typedef struct packed {
      token_kind_type     kind;
      logic signed [31:0] value;
      logic [7:0]         sym_char;
   } rsp_item_type;

   // All results of one character, in emission order
   typedef struct packed {
      rsp_item_type [MAX_RESULTS-1:0] item;
      logic [COUNT_W-1:0]             count;
   } rsp_group_type;

endpackage

// ----- rtl/core/sexl_lexer.sv -----
// ----------------------------------------------------------------------------
// sexl_lexer: lexer state and per-character token logic
// Holds the mode, the number magnitude and the pending sign, and works out in
// one pass the group of results that a character or an end mark causes.
// ----------------------------------------------------------------------------
module sexl_lexer
   import sexl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    in_char,
   input  logic          end_of_input,
   output rsp_group_type group
);

   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;

   lex_mode_type mode_ff, mode_in;
   logic [31:0]  acc_ff, acc_in;
   logic         neg_ff, neg_in;

   logic         do_finish;
   logic         do_fresh;
   logic [31:0]  acc_times_ten;
   logic [31:0]  digit_value;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_sym_start(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == 8'h3C) || (c == 8'h3D) || (c == 8'h3E) ||
             (c == 8'h2A) || (c == 8'h2F) || (c == 8'h23);
   endfunction

   function automatic logic is_sym_cont(input logic [7:0] c);
      return is_sym_start(c) || is_digit(c) ||
             (c == 8'h3F) || (c == 8'h21) || (c == CHAR_MINUS);
   endfunction

   function automatic rsp_item_type make_item(input token_kind_type kind,
                                              input logic [31:0] value,
                                              input logic [7:0] sym_char);
      rsp_item_type r;
      r.kind     = kind;
      r.value    = value;
      r.sym_char = sym_char;
      return r;
   endfunction

   // Digits '0'..'9' carry their value in the low nibble
   assign digit_value   = {28'd0, in_char[3:0]};
   assign acc_times_ten = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0};

   // Work out the result group and the next lexer state
   always_comb begin
      group     = '0;
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      do_finish = 1'b0;
      do_fresh  = 1'b0;

      if (end_of_input) begin
         do_finish = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_SIGN: begin
               if (is_digit(in_char)) begin
                  mode_in = MODE_NUM;
                  acc_in  = digit_value;
               end else begin
                  do_finish = 1'b1;
                  do_fresh  = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(in_char)) begin
                  acc_in = acc_times_ten + digit_value;
               end else begin
                  do_finish = 1'b1;
                  do_fresh  = 1'b1;
               end
            end
            MODE_SYM: begin
               if (is_sym_cont(in_char)) begin
                  group.item[group.count] = make_item(TOKEN_SYMCH, 32'd0, in_char);
                  group.count = group.count + 1'b1;
               end else begin
                  do_finish = 1'b1;
                  do_fresh  = 1'b1;
               end
            end
            default: begin
               mode_in  = MODE_IDLE;
               do_fresh = 1'b1;
            end
         endcase
      end

      // Close the pending token and drop back to idle
      if (do_finish) begin
         unique case (mode_ff)
            MODE_SIGN: begin
               group.item[group.count] = make_item(TOKEN_SYMCH, 32'd0,
                                                   neg_ff ? CHAR_MINUS : CHAR_PLUS);
               group.count = group.count + 1'b1;
               group.item[group.count] = make_item(TOKEN_SYMEND, 32'd0, 8'd0);
               group.count = group.count + 1'b1;
            end
            MODE_NUM: begin
               group.item[group.count] = make_item(TOKEN_CONST,
                                                   neg_ff ? (32'd0 - acc_ff) : acc_ff,
                                                   8'd0);
               group.count = group.count + 1'b1;
            end
            MODE_SYM: begin
               group.item[group.count] = make_item(TOKEN_SYMEND, 32'd0, 8'd0);
               group.count = group.count + 1'b1;
            end
            default: begin
            end
         endcase
         mode_in = MODE_IDLE;
         acc_in  = 32'd0;
         neg_in  = 1'b0;
      end

      // Lex the character from idle
      if (do_fresh) begin
         if (is_ws(in_char)) begin
         end else if (in_char == CHAR_OPEN) begin
            group.item[group.count] = make_item(TOKEN_OPEN, 32'd0, 8'd0);
            group.count = group.count + 1'b1;
         end else if (in_char == CHAR_CLOSE) begin
            group.item[group.count] = make_item(TOKEN_CLOSE, 32'd0, 8'd0);
            group.count = group.count + 1'b1;
         end else if (in_char == CHAR_DOT) begin
            group.item[group.count] = make_item(TOKEN_DOT, 32'd0, 8'd0);
            group.count = group.count + 1'b1;
         end else if (in_char == CHAR_QUOTE) begin
            group.item[group.count] = make_item(TOKEN_QUOTE, 32'd0, 8'd0);
            group.count = group.count + 1'b1;
         end else if ((in_char == CHAR_PLUS) || (in_char == CHAR_MINUS)) begin
            mode_in = MODE_SIGN;
            neg_in  = (in_char == CHAR_MINUS);
            acc_in  = 32'd0;
         end else if (is_digit(in_char)) begin
            mode_in = MODE_NUM;
            neg_in  = 1'b0;
            acc_in  = digit_value;
         end else if (is_sym_start(in_char)) begin
            mode_in = MODE_SYM;
            group.item[group.count] = make_item(TOKEN_SYMCH, 32'd0, in_char);
            group.count = group.count + 1'b1;
         end else begin
            group.item[group.count] = make_item(TOKEN_ERROR, 32'd0, 8'd0);
            group.count = group.count + 1'b1;
         end
      end

      if (end_of_input) begin
         group.item[group.count] = make_item(TOKEN_END, 32'd0, 8'd0);
         group.count = group.count + 1'b1;
      end
   end

   // Advance the lexer state once per processed character
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= 32'd0;
         neg_ff  <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         neg_ff  <= neg_in;
      end
   end

endmodule

// ----- rtl/core/sexl_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// sexl_rsp_queue: result group register and serializer
// Holds the results of one character and hands them out one per transfer,
// marking the last one. Frees itself in the cycle its last result leaves.
// ----------------------------------------------------------------------------
module sexl_rsp_queue
   import sexl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_group_type group,
   output logic          free,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output rsp_item_type  rsp_item,
   output logic          rsp_tlast
);

   rsp_item_type       items_ff [MAX_RESULTS];
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               at_last;

   assign at_last    = (COUNT_W'(index_ff) + 1'b1) == count_ff;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = at_last;
   assign rsp_item   = items_ff[index_ff];
   assign free       = (count_ff == '0) || (at_last && rsp_tready);

   // Step through the group, reload when it is spent
   always_comb begin
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         count_in = group.count;
         index_in = '0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (at_last) begin
            count_in = '0;
            index_in = '0;
         end else begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   // Hold the group payload; item 0 is emitted first
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            items_ff[i] <= group.item[i];
         end
      end
   end

endmodule

// ----- rtl/core/s_expression_lexer.sv -----
// ----------------------------------------------------------------------------
// s_expression_lexer: streaming tokenizer for Lisp S-expressions
// One character or end mark in per transfer, token events out.
// ----------------------------------------------------------------------------
// Each request carries one character byte, or with req_tuser set the end of
// the stream. Results come out one per transfer, rsp_tlast marking the last
// result of a character; digits that extend a number or sign give no result,
// nor does whitespace, a digit or a sign with no token open. A character passes
// an input register, is lexed combinationally and its results (up to three)
// are held in a result register. Throughput is one character per cycle while
// each yields at most one result and rsp_tready stays high; a character with n
// results occupies the single result port for n transfers, and the next
// character is lexed in the cycle its last result is taken.
// ----------------------------------------------------------------------------
module s_expression_lexer
   import sexl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] constant_value, [39:32] symbol_char
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   logic          in_valid_ff;
   logic [7:0]    in_char_ff;
   logic          in_eoi_ff;
   logic          queue_free;
   logic          lex_step;
   rsp_group_type group;
   rsp_item_type  rsp_item;

   assign lex_step   = in_valid_ff && queue_free;
   assign req_tready = !in_valid_ff || lex_step;

   // Input register: take a transfer whenever it is empty or the held character moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_eoi_ff  <= req_tuser;
      end
   end

   sexl_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .step         (lex_step),
      .in_char      (in_char_ff),
      .end_of_input (in_eoi_ff),
      .group        (group)
   );

   sexl_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (lex_step),
      .group      (group),
      .free       (queue_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .rsp_tlast  (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {rsp_item.sym_char, rsp_item.value};
   assign rsp_tuser = rsp_item.kind;

endmodule

// ----- sim/lexer_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lexer_tb_pkg: token prediction and checking for the S-expression lexer
// Tracks the lexer state character by character, queues the token events
// each character should produce and compares them with what the block emits.
// ----------------------------------------------------------------------------
package lexer_tb_pkg;
   import sexl_pkg::*;

   typedef struct {
      token_kind_type kind;
      logic [31:0]    value;
      logic [7:0]     symch;
      logic           last;
   } token_event_type;

   class token_scoreboard;
      lex_mode_type    mode;
      logic [31:0]     magnitude;
      logic            negative;
      token_event_type expected_tokens[$];
      int              fail_count;

      function new();
         mode       = MODE_IDLE;
         magnitude  = '0;
         negative   = 1'b0;
         fail_count = 0;
      endfunction

      // space, or tab through carriage return
      function bit is_space(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_sym_start(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "<" ||
                c == "=" || c == ">" || c == "*" || c == "/" || c == "#";
      endfunction

      function bit is_sym_cont(logic [7:0] c);
         return is_sym_start(c) || is_digit(c) || c == "?" || c == "!" || c == "-";
      endfunction

      function void push_token(token_kind_type kind, logic [31:0] value, logic [7:0] symch);
         token_event_type t;
         t.kind  = kind;
         t.value = value;
         t.symch = symch;
         t.last  = 1'b0;
         expected_tokens.push_back(t);
      endfunction

      // Flush whatever token is open and drop back to idle
      function void close_token();
         case (mode)
            MODE_SIGN: begin
               push_token(TOKEN_SYMCH, '0, negative ? "-" : "+");
               push_token(TOKEN_SYMEND, '0, '0);
            end
            MODE_NUM: push_token(TOKEN_CONST, negative ? 32'd0 - magnitude : magnitude, '0);
            MODE_SYM: push_token(TOKEN_SYMEND, '0, '0);
            default: ;
         endcase
         mode      = MODE_IDLE;
         magnitude = '0;
         negative  = 1'b0;
      endfunction

      // Lex a character with no token open
      function void start_token(logic [7:0] c);
         if (is_space(c)) return;
         case (c)
            "(": push_token(TOKEN_OPEN, '0, '0);
            ")": push_token(TOKEN_CLOSE, '0, '0);
            ".": push_token(TOKEN_DOT, '0, '0);
            "'": push_token(TOKEN_QUOTE, '0, '0);
            "+", "-": begin
               mode      = MODE_SIGN;
               negative  = (c == "-");
               magnitude = '0;
            end
            default: begin
               if (is_digit(c)) begin
                  mode      = MODE_NUM;
                  negative  = 1'b0;
                  magnitude = 32'(c - "0");
               end else if (is_sym_start(c)) begin
                  mode = MODE_SYM;
                  push_token(TOKEN_SYMCH, '0, c);
               end else begin
                  push_token(TOKEN_ERROR, '0, '0);
               end
            end
         endcase
      endfunction

      // Predict the tokens of one accepted character or end mark
      function void note_char(logic [7:0] c, logic eoi);
         int queued;
         queued = expected_tokens.size();
         if (eoi) begin
            close_token();
            push_token(TOKEN_END, '0, '0);
         end else begin
            case (mode)
               MODE_SIGN: begin
                  if (is_digit(c)) begin
                     mode      = MODE_NUM;
                     magnitude = 32'(c - "0");
                  end else begin
                     close_token();
                     start_token(c);
                  end
               end
               MODE_NUM: begin
                  if (is_digit(c)) begin
                     magnitude = magnitude * 32'd10 + 32'(c - "0");
                  end else begin
                     close_token();
                     start_token(c);
                  end
               end
               MODE_SYM: begin
                  if (is_sym_cont(c)) begin
                     push_token(TOKEN_SYMCH, '0, c);
                  end else begin
                     close_token();
                     start_token(c);
                  end
               end
               default: start_token(c);
            endcase
         end
         // Mark the final event of this character
         if (expected_tokens.size() > queued)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
      endfunction

      function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         fail_count++;
      endfunction

      // Compare one emitted token with the oldest prediction
      function void check_token(logic [3:0] kind, logic [31:0] value, logic [7:0] symch,
                                logic last);
         token_event_type want;
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, got kind %0h value %0h char %0h",
                     $time, kind, value, symch);
            fail_count++;
            return;
         end
         want = expected_tokens.pop_front();
         if (kind !== want.kind)   report_mismatch("token_kind", 32'(want.kind), 32'(kind));
         if (value !== want.value) report_mismatch("constant_value", want.value, value);
         if (symch !== want.symch) report_mismatch("symbol_char", 32'(want.symch), 32'(symch));
         if (last !== want.last)   report_mismatch("last_of_run", 32'(want.last), 32'(last));
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction
   endclass

endpackage

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the S-expression lexer
// Feeds directed character sequences and then random token streams with
// noise and early end marks, stalls both sides at random, and checks every
// token event against a prediction kept alongside the block.
// ----------------------------------------------------------------------------
module tb;
   import sexl_pkg::*;
   import lexer_tb_pkg::*;

   localparam int ITEM_TARGET   = 250;
   localparam int IDLE_PERCENT  = 24;
   localparam int HOLD_START    = 40;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_char
   logic        req_tuser;   // [0] end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] constant_value, [39:32] symbol_char
   logic [3:0]  rsp_tuser;   // [3:0] token_kind
   logic        rsp_tlast;

   token_scoreboard book = new();

   // Character stream, end mark in bit 8
   logic [8:0] char_stream[$];
   bit         feed_done;
   int         taken;

   string sym_start_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ<=>*/#";
   string sym_cont_chars  =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ<=>*/#0123456789?!-";
   string space_chars     = " \t\n\013\014\r";

   s_expression_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   task automatic add_byte(logic [7:0] c);
      char_stream.push_back({1'b0, c});
   endtask

   task automatic add_text(string s);
      foreach (s[i]) add_byte(s[i]);
   endtask

   // End mark carries a random byte that must be ignored
   task automatic add_end();
      char_stream.push_back({1'b1, 8'($urandom_range(0, 255))});
   endtask

   // Build well-formed tokens with random content, mixed with noise and early ends
   task automatic add_random_tokens();
      int counted;
      int pick;
      int len;
      counted = char_stream.size();
      while (counted < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            // signed or unsigned constant, now and then long enough to wrap
            if ($urandom_range(0, 2) == 0) begin
               add_byte($urandom_range(0, 1) ? "-" : "+");
               counted++;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
            repeat (len) add_byte(8'("0" + $urandom_range(0, 9)));
            counted += len;
         end else if (pick < 45) begin
            add_byte(sym_start_chars[$urandom_range(0, sym_start_chars.len() - 1)]);
            len = $urandom_range(0, 5);
            repeat (len) add_byte(sym_cont_chars[$urandom_range(0, sym_cont_chars.len() - 1)]);
            counted += len + 1;
         end else if (pick < 65) begin
            case ($urandom_range(0, 3))
               0: add_byte("(");
               1: add_byte(")");
               2: add_byte(".");
               default: add_byte("'");
            endcase
            counted++;
         end else if (pick < 72) begin
            add_byte($urandom_range(0, 1) ? "+" : "-");
            counted++;
         end else if (pick < 88) begin
            add_byte(8'($urandom_range(0, 255)));
            counted++;
         end else begin
            add_end();
            counted++;
         end
         // optional whitespace between tokens
         if ($urandom_range(0, 3) != 0) begin
            add_byte(space_chars[$urandom_range(0, space_chars.len() - 1)]);
            counted++;
         end
      end
      add_end();
   endtask

   // Request side: offer characters, idle at random outside the burst window
   initial begin
      int idx;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      feed_done  = 1'b0;

      // every token kind, lone signs, bad bytes, whitespace, end in each mode
      add_text("().'-7x?+(-");
      add_end();
      add_byte(8'h00);
      add_byte(8'hff);
      add_text("\t\r5");
      add_end();
      add_text("a");
      add_end();
      add_end();
      add_text("#! ");
      add_random_tokens();

      do @(negedge clock); while (reset !== 1'b0);
      idx = 0;
      while (idx < char_stream.size()) begin
         if ((idx >= 120 && idx < 180) || $urandom_range(0, 99) >= IDLE_PERCENT) begin
            req_tvalid = 1'b1;
            req_tuser  = char_stream[idx][8];
            req_tdata  = char_stream[idx][7:0];
            do @(posedge clock); while (!req_tready);
            book.note_char(req_tdata, req_tuser);
            idx++;
         end else begin
            req_tvalid = 1'b0;
            @(posedge clock);
         end
         @(negedge clock);
      end
      req_tvalid = 1'b0;
      feed_done  = 1'b1;
   end

   // Response side: one long hold-off, a burst window, random stalls elsewhere
   initial begin
      int hold_left;
      bit held;
      hold_left  = 0;
      held       = 1'b0;
      taken      = 0;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset !== 1'b0);
      forever begin
         if (!held && taken >= HOLD_START) begin
            hold_left = HOLD_CYCLES;
            held      = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else if (taken >= 100 && taken < 170) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            book.check_token(rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32], rsp_tlast);
            taken++;
         end
         @(negedge clock);
      end
   end

   // Drain, let stray tokens show up, then report
   initial begin
      wait (feed_done);
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout, %0d tokens still expected", book.pending());
      $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sexl_pkg.sv
rtl/core/sexl_lexer.sv
rtl/core/sexl_rsp_queue.sv
rtl/core/s_expression_lexer.sv
sim/lexer_tb_pkg.sv
sim/tb.sv
